// File: hdl/bfp_pkg.sv
// shared types and constants for the binary fraction period finder
// no dependencies

package bfp_pkg;

	// one recorded division step: digit in bit 6, remainder in bits 5..0
	typedef logic [6:0] pair_t;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_ZERO_DEN = 2'd1;
	localparam status_t STATUS_NUM_GE   = 2'd2;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DIV     = 6'b000010,
		S_SEARCH  = 6'b000100,
		S_WRITE   = 6'b001000,
		S_EMIT_RD = 6'b010000,
		S_EMIT    = 6'b100000
	} state_t;

	// one step of binary long division
	function automatic pair_t div_step(input logic [5:0] rem, input logic [5:0] den);
		logic [6:0] twice;
		logic [6:0] diff;
		logic       dig;
		twice = {rem, 1'b0};
		dig   = (twice >= {1'b0, den});
		diff  = twice - (dig ? {1'b0, den} : 7'd0);
		return {dig, diff[5:0]};
	endfunction

endpackage

// File: hdl/bfp_pair_store.sv
// pair table: one write port, one registered read port
// depends on bfp_pkg

module bfp_pair_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  bfp_pkg::pair_t   wdata,
	input  logic [AW-1:0]    raddr,
	output bfp_pkg::pair_t   rdata
);

	bfp_pkg::pair_t mem [DEPTH];
	bfp_pkg::pair_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/binary_fraction_period_finder_top.sv
// top level of the binary fraction period finder: sequencer, division step and emission
// depends on bfp_pkg and bfp_pair_store

// Raise start with numerator and denominator while busy is low; the item is taken at that
// edge. Results come out one per strobe (valid high for one cycle) and cannot be held off.
// A bad item (zero denominator, or numerator not below denominator) gives one error result
// in the next cycle. Otherwise the block runs long division one digit at a time; each new
// (digit, remainder) pair is looked up in the pair table through its single read port, one
// entry a cycle, and is recorded only if it is not found. Once a pair repeats or the table
// is full, the digits are emitted in order, each read from the pair table before its strobe.

module binary_fraction_period_finder_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [5:0] numerator,
	input  logic [5:0] denominator,
	output logic       valid,
	output logic       digit,
	output logic       period_start,
	output logic       last_digit,
	output logic [1:0] status
);

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int NW     = (CW > 7) ? CW : 7;
	localparam int MaxOut = 64;

	bfp_pkg::state_t  state_q;
	logic [5:0]       den_q;
	logic [5:0]       rem_q;
	bfp_pkg::pair_t   pair_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    k_q;
	logic             rd_vld_q;
	logic [AW-1:0]    rd_idx_q;
	logic             found_q;
	logic [AW-1:0]    pos_q;
	logic [NW-1:0]    e_q;
	logic             valid_q;
	logic             digit_q;
	logic             ps_q;
	logic             last_q;
	bfp_pkg::status_t status_q;

	logic             mem_we;
	logic [AW-1:0]    mem_raddr;
	bfp_pkg::pair_t   mem_rdata;
	logic             hit;
	logic [NW-1:0]    cnt_w;
	logic [NW-1:0]    n_c;
	logic [NW-1:0]    e_nxt;
	logic             e_last;

	assign mem_we    = (state_q == bfp_pkg::S_WRITE);
	assign mem_raddr = (state_q == bfp_pkg::S_SEARCH) ? k_q[AW-1:0] : e_q[AW-1:0];
	assign hit       = rd_vld_q && (mem_rdata == pair_q);
	assign cnt_w     = NW'(count_q);
	assign n_c       = (cnt_w > NW'(MaxOut)) ? NW'(MaxOut) : cnt_w;
	assign e_nxt     = e_q + NW'(1);
	assign e_last    = (e_nxt == n_c);

	bfp_pair_store #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(pair_q),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bfp_pkg::S_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
			e_q      <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				bfp_pkg::S_IDLE: begin
					if (start) begin
						if (denominator == 6'd0) begin
							valid_q <= 1'b1;
						end else if (numerator >= denominator) begin
							valid_q <= 1'b1;
						end else begin
							count_q <= '0;
							found_q <= 1'b0;
							state_q <= bfp_pkg::S_DIV;
						end
					end
				end
				bfp_pkg::S_DIV: begin
					k_q      <= '0;
					rd_vld_q <= 1'b0;
					state_q  <= bfp_pkg::S_SEARCH;
				end
				bfp_pkg::S_SEARCH: begin
					if (k_q < count_q) begin
						rd_vld_q <= 1'b1;
						k_q      <= k_q + CW'(1);
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (hit) begin
						found_q  <= 1'b1;
						rd_vld_q <= 1'b0;
						e_q      <= '0;
						state_q  <= bfp_pkg::S_EMIT_RD;
					end else if (k_q == count_q && !rd_vld_q) begin
						state_q <= bfp_pkg::S_WRITE;
					end
				end
				bfp_pkg::S_WRITE: begin
					count_q <= count_q + CW'(1);
					if (count_q == CW'(TABLE_DEPTH - 1)) begin
						e_q     <= '0;
						state_q <= bfp_pkg::S_EMIT_RD;
					end else begin
						state_q <= bfp_pkg::S_DIV;
					end
				end
				bfp_pkg::S_EMIT_RD: begin
					state_q <= bfp_pkg::S_EMIT;
				end
				bfp_pkg::S_EMIT: begin
					valid_q <= 1'b1;
					e_q     <= e_nxt;
					state_q <= e_last ? bfp_pkg::S_IDLE : bfp_pkg::S_EMIT_RD;
				end
				default: begin
					state_q <= bfp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			bfp_pkg::S_IDLE: begin
				den_q    <= denominator;
				rem_q    <= numerator;
				digit_q  <= 1'b0;
				ps_q     <= 1'b0;
				last_q   <= 1'b1;
				status_q <= (denominator == 6'd0) ? bfp_pkg::STATUS_ZERO_DEN
				                                  : bfp_pkg::STATUS_NUM_GE;
			end
			bfp_pkg::S_DIV: begin
				pair_q <= bfp_pkg::div_step(rem_q, den_q);
			end
			bfp_pkg::S_SEARCH: begin
				rd_idx_q <= k_q[AW-1:0];
				if (hit) begin
					pos_q <= rd_idx_q;
				end
			end
			bfp_pkg::S_WRITE: begin
				rem_q <= pair_q[5:0];
			end
			bfp_pkg::S_EMIT: begin
				digit_q  <= mem_rdata[6];
				ps_q     <= found_q && (e_q == NW'(pos_q));
				last_q   <= e_last;
				status_q <= bfp_pkg::STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != bfp_pkg::S_IDLE);
	assign valid        = valid_q;
	assign digit        = digit_q;
	assign period_start = ps_q;
	assign last_digit   = last_q;
	assign status       = status_q;

`ifndef NO_ASSERTIONS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != bfp_pkg::STATUS_OK |-> last_digit)
		else $error("error result not marked last");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && denominator == 6'd0 |=>
		valid && status == bfp_pkg::STATUS_ZERO_DEN)
		else $error("zero denominator not answered");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("pair count beyond table depth");

	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfp_pkg::S_EMIT |=> valid && status == bfp_pkg::STATUS_OK && !busy == last_digit)
		else $error("emitted digit out of step with sequencer");
`endif

endmodule
